/* src/sllist_pkg.sv */
// shared types and constants of the singly linked list engine
// used by the core, the node ram wrapper users and the port checker
`default_nettype none

package sllist_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int ST_W         = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD   = 3'd0,
        OP_INS_TAIL   = 3'd1,
        OP_INS_AFTER  = 3'd2,
        OP_INS_BEFORE = 3'd3,
        OP_DEL_HEAD   = 3'd4,
        OP_DEL_TAIL   = 3'd5,
        OP_DEL_AFTER  = 3'd6,
        OP_DUMP       = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_NOKEY   = 3'd2,
        ST_NOAFTER = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

endpackage

`default_nettype wire

/* src/sllist_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sllist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/singly_linked_list_engine_core.sv */
// top level of the singly linked list engine: sequencer, free map, node rams
// depends on sllist_pkg and sllist_ram
//
// usage
//   a request transfers when start is high and busy is low; it carries an
//   operation, a value to insert and a key to search for
//   every request gives one result on o_valid, o_status, o_out_value, o_last;
//   a dump gives one result per list element, the last one marked by o_last
//   results show for one cycle and cannot be held off by the receiver
//   errors found at the head give their result straight from idle, head inserts
//   go straight to the node write and a head delete reads the head node first;
//   walks read each node visited from the rams and then evaluate it, over at
//   most CAPACITY nodes, and then write the changed nodes and links;
//   a dump gives its elements in list order, one per node read and evaluate
//   busy drops in the cycle that shows the last result of a request
//   reset empties the list and frees every node; node rams are not cleared
`default_nettype none

module singly_linked_list_engine_core
    import sllist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OP_W-1:0]          i_op,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    input  wire logic signed [DATA_W-1:0] i_match_key,
    output logic                          o_valid,
    output logic [ST_W-1:0]               o_status,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic                          o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam logic [LW-1:0] LNULL = LW'(CAPACITY);
    localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_EVAL  = 6'b000100,
        S_ALLOC = 6'b001000,
        S_LINK  = 6'b010000,
        S_FETCH = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic                      r_take, n_take;
    t_op                       r_op, n_op;
    logic signed [DATA_W-1:0]  r_val, n_val;
    logic signed [DATA_W-1:0]  r_key, n_key;
    logic [LW-1:0]             r_head, n_head;
    logic [CAPACITY-1:0]       r_free, n_free;
    logic [LW-1:0]             r_cur, n_cur;
    logic [LW-1:0]             r_prev, n_prev;
    logic [SW-1:0]             r_steps, n_steps;
    logic [AW-1:0]             r_new, n_new;
    logic [LW-1:0]             r_nlink, n_nlink;
    logic                      n_valid;
    logic [ST_W-1:0]           n_status;
    logic signed [DATA_W-1:0]  n_value;
    logic                      n_last;

    logic                      vw_en, lw_en;
    logic [AW-1:0]             vw_addr, lw_addr, rd_addr;
    logic [DATA_W-1:0]         vw_data, rd_value;
    logic [LW-1:0]             lw_data, rd_link, w_nxl;
    logic [AW-1:0]             w_free_idx;
    logic                      w_has_free, w_empty, w_last_step;

    sllist_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_values (
        .i_clk   (i_clk),
        .i_we    (vw_en),
        .i_waddr (vw_addr),
        .i_wdata (vw_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_value)
    );

    sllist_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_links (
        .i_clk   (i_clk),
        .i_we    (lw_en),
        .i_waddr (lw_addr),
        .i_wdata (lw_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_link)
    );

    always_comb begin
        w_free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_free_idx = AW'(i);
            end
        end
    end

    assign w_has_free  = |r_free;
    assign w_empty     = (r_head == LNULL);
    assign w_last_step = (r_steps == LAST_STEP);
    assign w_nxl       = (rd_link >= LNULL) ? LNULL : rd_link;
    assign rd_addr     = r_take ? r_new : r_cur[AW-1:0];
    assign busy        = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_take   = r_take;
        n_op     = r_op;
        n_val    = r_val;
        n_key    = r_key;
        n_head   = r_head;
        n_free   = r_free;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_new    = r_new;
        n_nlink  = r_nlink;
        n_valid  = 1'b0;
        n_status = ST_OK;
        n_value  = '0;
        n_last   = 1'b1;
        vw_en    = 1'b0;
        vw_addr  = r_new;
        vw_data  = r_val;
        lw_en    = 1'b0;
        lw_addr  = r_new;
        lw_data  = r_nlink;

        unique case (r_state)
            S_IDLE: begin
                n_take = 1'b0;
                if (start) begin
                    n_op    = t_op'(i_op);
                    n_val   = i_item_value;
                    n_key   = i_match_key;
                    n_cur   = r_head;
                    n_prev  = LNULL;
                    n_steps = '0;
                    n_new   = w_free_idx;
                    unique case (t_op'(i_op)) inside
                        OP_INS_HEAD: begin
                            n_nlink = r_head;
                            if (w_has_free) begin
                                n_state = S_ALLOC;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end
                        end
                        OP_INS_TAIL: begin
                            n_nlink = LNULL;
                            if (!w_empty) begin
                                n_state = S_READ;
                            end else if (w_has_free) begin
                                n_state = S_ALLOC;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end

            S_READ: begin
                n_state = S_EVAL;
            end

            S_EVAL: begin
                n_state = S_IDLE;
                unique case (r_op) inside
                    OP_DEL_HEAD: begin
                        n_valid = 1'b1;
                        n_value = rd_value;
                        n_head  = w_nxl;
                        n_free[r_cur[AW-1:0]] = 1'b1;
                    end
                    OP_INS_TAIL, OP_DEL_TAIL: begin
                        if (w_nxl == LNULL || w_last_step) begin
                            if (r_op == OP_DEL_TAIL) begin
                                n_valid = 1'b1;
                                n_value = rd_value;
                                n_free[r_cur[AW-1:0]] = 1'b1;
                                if (r_prev == LNULL) begin
                                    n_head = LNULL;
                                end else begin
                                    lw_en   = 1'b1;
                                    lw_addr = r_prev[AW-1:0];
                                    lw_data = LNULL;
                                end
                            end else if (w_has_free) begin
                                n_new   = w_free_idx;
                                n_nlink = LNULL;
                                n_state = S_ALLOC;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end
                        end else begin
                            n_prev  = r_cur;
                            n_cur   = w_nxl;
                            n_steps = r_steps + 1'b1;
                            n_state = S_READ;
                        end
                    end
                    OP_DUMP: begin
                        n_valid = 1'b1;
                        n_value = rd_value;
                        n_last  = (w_nxl == LNULL) || w_last_step;
                        if (!n_last) begin
                            n_cur   = w_nxl;
                            n_steps = r_steps + 1'b1;
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        if ($signed(rd_value) == r_key) begin
                            if (r_op == OP_DEL_AFTER) begin
                                if (w_nxl == LNULL) begin
                                    n_valid  = 1'b1;
                                    n_status = ST_NOAFTER;
                                end else begin
                                    n_new   = w_nxl[AW-1:0];
                                    n_take  = 1'b1;
                                    n_state = S_FETCH;
                                end
                            end else if (w_has_free) begin
                                n_new   = w_free_idx;
                                n_nlink = (r_op == OP_INS_AFTER) ? w_nxl : r_cur;
                                n_state = S_ALLOC;
                            end else begin
                                n_valid  = 1'b1;
                                n_status = ST_FULL;
                            end
                        end else if (w_nxl == LNULL || w_last_step) begin
                            n_valid  = 1'b1;
                            n_status = ST_NOKEY;
                        end else begin
                            n_prev  = r_cur;
                            n_cur   = w_nxl;
                            n_steps = r_steps + 1'b1;
                            n_state = S_READ;
                        end
                    end
                endcase
            end

            S_ALLOC: begin
                vw_en  = 1'b1;
                lw_en  = 1'b1;
                n_free[r_new] = 1'b0;
                n_state = S_IDLE;
                unique case (r_op) inside
                    OP_INS_AFTER: begin
                        n_state = S_LINK;
                    end
                    OP_INS_TAIL: begin
                        if (w_empty) begin
                            n_head  = LW'(r_new);
                            n_valid = 1'b1;
                        end else begin
                            n_state = S_LINK;
                        end
                    end
                    OP_INS_BEFORE: begin
                        if (r_prev == LNULL) begin
                            n_head  = LW'(r_new);
                            n_valid = 1'b1;
                        end else begin
                            n_state = S_LINK;
                        end
                    end
                    default: begin
                        n_head  = LW'(r_new);
                        n_valid = 1'b1;
                    end
                endcase
            end

            S_LINK: begin
                lw_en   = 1'b1;
                lw_addr = (r_op == OP_INS_BEFORE) ? r_prev[AW-1:0] : r_cur[AW-1:0];
                lw_data = LW'(r_new);
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            S_FETCH: begin
                n_state = S_LINK;
                if (!r_take) begin
                    n_valid = 1'b1;
                    n_value = rd_value;
                    lw_en   = 1'b1;
                    lw_addr = r_cur[AW-1:0];
                    lw_data = w_nxl;
                    n_free[r_new] = 1'b1;
                    n_state = S_IDLE;
                end
                n_take = 1'b0;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_take  <= 1'b0;
            r_head  <= LNULL;
            r_free  <= '1;
            o_valid <= 1'b0;
        end else begin
            r_state <= (r_state == S_FETCH && r_take) ? S_FETCH : n_state;
            r_take  <= n_take;
            r_head  <= n_head;
            r_free  <= n_free;
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_val       <= n_val;
        r_key       <= n_key;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_steps     <= n_steps;
        r_new       <= n_new;
        r_nlink     <= n_nlink;
        o_status    <= n_status;
        o_out_value <= n_value;
        o_last      <= n_last;
    end

endmodule

`default_nettype wire

/* src/sllist_chk.sv */
// port level checker for the singly linked list engine, bound to the core
// depends on sllist_pkg
`default_nettype none

module sllist_chk
    import sllist_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     busy,
    input wire logic                     o_valid,
    input wire logic [ST_W-1:0]          o_status,
    input wire logic signed [DATA_W-1:0] o_out_value,
    input wire logic                     o_last
);

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("busy after final result transfer");

    a_dump_goes_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> busy)
        else $error("dump stopped before its final element");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_last && o_out_value == '0)
        else $error("error result not single or not zero");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_FULL)
        else $error("status code out of range");

    a_quiet_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid && !busy)
        else $error("activity right after reset");

endmodule

bind singly_linked_list_engine_core sllist_chk u_sllist_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_out_value (o_out_value),
    .o_last      (o_last)
);

`default_nettype wire
